// ===== src/encoder_position_stall_watch_assert.svh =====
// Assertion macros shared by the stall watch modules.
`ifndef ENCODER_POSITION_STALL_WATCH_ASSERT_SVH
`define ENCODER_POSITION_STALL_WATCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eps_pkg.sv =====
// Types and codes shared by the stall watch controller and datapath.
`default_nettype none

package eps_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [7:0] REG_INTERVAL = 8'd0;
  localparam logic [7:0] REG_HORIZON  = 8'd1;
  localparam logic [7:0] REG_REQ_FWD  = 8'd2;
  localparam logic [7:0] REG_REQ_BWD  = 8'd3;

  localparam logic [23:0] RST_INTERVAL = 24'd100000;
  localparam logic [23:0] RST_HORIZON  = 24'd500000;
  localparam logic [15:0] RST_REQ_FWD  = 16'd10;
  localparam logic [15:0] RST_REQ_BWD  = 16'd10;

  typedef enum logic [1:0] {
    MOT_STOPPED = 2'd0,
    MOT_FWD     = 2'd1,
    MOT_BWD     = 2'd2
  } motion_t;

  typedef struct packed {
    logic take;
    logic scan;
    logic add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic miss;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/eps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module eps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/eps_ctrl.sv =====
// Sequencing state machine of the stall watch: accept, scan, add, emit.
`default_nettype none
`include "encoder_position_stall_watch_assert.svh"

module eps_ctrl import eps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd_o         = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.take = 1'b1;
          state_nxt  = sts_i.needs_scan ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_nxt = sts_i.miss ? S_EMIT : S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd_o.load_out = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `EPS_ASSERT_IMP(a_add_after_clean_scan, clk, rst_n, state_r == S_ADD,
    $past(state_r) == S_SCAN && !$past(sts_i.miss), "milestone add without a clean scan")
  `EPS_ASSERT_IMP(a_load_no_overwrite, clk, rst_n, cmd_o.load_out,
    !out_valid_r || out_tready, "result word overwritten while waiting")
  `EPS_ASSERT_IMP(a_valid_from_load, clk, rst_n, $rose(out_valid_r),
    $past(cmd_o.load_out), "result valid raised without a load")

endmodule

`default_nettype wire

// ===== src/eps_dp.sv =====
// Datapath of the stall watch: position, motion, milestone ring and result word.
`default_nettype none
`include "encoder_position_stall_watch_assert.svh"

module eps_dp import eps_pkg::*; #(
  parameter int MILESTONE_SLOTS = 8,
  parameter int POSITION_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [1:0]  in_tuser,
  input  logic [71:0] in_tdata,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [39:0] out_tdata
);

  localparam int AW   = (MILESTONE_SLOTS > 1) ? $clog2(MILESTONE_SLOTS) : 1;
  localparam int CW   = $clog2(MILESTONE_SLOTS + 1);
  localparam int PB   = POSITION_BITS;
  localparam int CMPW = (PB > 32) ? PB : 32;
  localparam int EW   = (PB > 16) ? PB : 16;
  localparam int CHKW = 32 + PB;

  logic [23:0] interval_r, horizon_r;
  logic [15:0] req_fwd_r, req_bwd_r;

  logic [PB-1:0] pos_r, pos_nxt;
  motion_t       motion_r, motion_nxt;
  logic          prev_r, prev_nxt, prev_vld_r, prev_vld_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic          rd_vld_r, rd_vld_nxt, miss_r, miss_nxt;
  logic          ev_r, ev_nxt, stall_r, stall_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [39:0]   out_r;

  logic [31:0]          in_target, in_now;
  logic                 in_level;
  logic signed [CMPW-1:0] tgt_ext, pos_ext;

  logic [CHKW-1:0] chk_rdata;
  logic [31:0]     crt_rdata;
  logic [31:0]     due_rd;
  logic [PB-1:0]   goal_rd;

  logic            wr_en, late;
  logic [AW-1:0]   wr_idx;
  logic [31:0]     next_crt, due_new;
  logic [EW-1:0]   goal_sum;
  logic [PB-1:0]   goal_new;
  logic            slot_left;

  assign in_target = in_tdata[31:0];
  assign in_level  = in_tdata[32];
  assign in_now    = in_tdata[64:33];
  assign tgt_ext   = CMPW'($signed(in_target));
  assign pos_ext   = CMPW'($signed(pos_r));

  assign due_rd    = chk_rdata[31:0];
  assign goal_rd   = chk_rdata[CHKW-1:32];
  assign slot_left = (ptr_r < cnt_r);

  // New milestone: slot index, time gate and goal.
  assign next_crt = crt_rdata + {8'd0, interval_r};
  assign late     = (cnt_r == '0) || !(now_r < next_crt);
  assign wr_idx   = (cnt_r == '0) ? '0 :
                    ((last_r == AW'(MILESTONE_SLOTS - 1)) ? '0 : last_r + 1'b1);
  assign due_new  = now_r + {8'd0, horizon_r};
  assign goal_sum = (motion_r == MOT_FWD) ? (EW'(pos_r) + EW'(req_fwd_r))
                                          : (EW'(pos_r) - EW'(req_bwd_r));
  assign goal_new = goal_sum[PB-1:0];
  assign wr_en    = cmd_i.add && late;

  assign sts_o.needs_scan = (in_tuser == ACT_TICK) && (motion_r != MOT_STOPPED);
  assign sts_o.scan_done  = !slot_left && !rd_vld_r;
  assign sts_o.miss       = miss_r;

  always_comb begin
    pos_nxt      = pos_r;
    motion_nxt   = motion_r;
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    ptr_nxt      = ptr_r;
    rd_vld_nxt   = rd_vld_r;
    miss_nxt     = miss_r;
    ev_nxt       = ev_r;
    stall_nxt    = stall_r;
    now_nxt      = now_r;
    if (cmd_i.take) begin
      now_nxt    = in_now;
      ptr_nxt    = '0;
      rd_vld_nxt = 1'b0;
      miss_nxt   = 1'b0;
      ev_nxt     = 1'b0;
      stall_nxt  = 1'b0;
      case (in_tuser)
        ACT_TICK: begin
          if (motion_r != MOT_STOPPED) begin
            if (prev_vld_r && !prev_r && in_level) begin
              pos_nxt = (motion_r == MOT_FWD) ? pos_r + 1'b1 : pos_r - 1'b1;
            end
            prev_nxt     = in_level;
            prev_vld_nxt = 1'b1;
          end
        end
        ACT_START: begin
          cnt_nxt    = '0;
          last_nxt   = '0;
          motion_nxt = (tgt_ext < pos_ext) ? MOT_BWD : MOT_FWD;
        end
        ACT_STOP: begin
          motion_nxt = MOT_STOPPED;
          ev_nxt     = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan) begin
      rd_vld_nxt = slot_left;
      if (slot_left) begin
        ptr_nxt = ptr_r + 1'b1;
      end
      // A due milestone that the position has not reached is a miss.
      if (rd_vld_r && (due_rd < now_r)) begin
        if ((motion_r == MOT_FWD) && ($signed(pos_r) < $signed(goal_rd))) begin
          miss_nxt = 1'b1;
        end
        if ((motion_r == MOT_BWD) && ($signed(goal_rd) < $signed(pos_r))) begin
          miss_nxt = 1'b1;
        end
      end
      if (sts_o.scan_done && miss_r) begin
        motion_nxt = MOT_STOPPED;
        ev_nxt     = 1'b1;
        stall_nxt  = 1'b1;
      end
    end
    if (wr_en) begin
      last_nxt = wr_idx;
      if (cnt_r != CW'(MILESTONE_SLOTS)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RST_INTERVAL;
      horizon_r  <= RST_HORIZON;
      req_fwd_r  <= RST_REQ_FWD;
      req_bwd_r  <= RST_REQ_BWD;
      pos_r      <= '0;
      motion_r   <= MOT_STOPPED;
      prev_r     <= 1'b0;
      prev_vld_r <= 1'b0;
      cnt_r      <= '0;
      last_r     <= '0;
      ptr_r      <= '0;
      rd_vld_r   <= 1'b0;
      miss_r     <= 1'b0;
      ev_r       <= 1'b0;
      stall_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_INTERVAL: interval_r <= cfg_data;
          REG_HORIZON:  horizon_r  <= cfg_data;
          REG_REQ_FWD:  req_fwd_r  <= cfg_data[15:0];
          REG_REQ_BWD:  req_bwd_r  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      pos_r      <= pos_nxt;
      motion_r   <= motion_nxt;
      prev_r     <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
      cnt_r      <= cnt_nxt;
      last_r     <= last_nxt;
      ptr_r      <= ptr_nxt;
      rd_vld_r   <= rd_vld_nxt;
      miss_r     <= miss_nxt;
      ev_r       <= ev_nxt;
      stall_r    <= stall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (cmd_i.load_out) begin
      out_r <= {4'd0, stall_r, ev_r, motion_r, pos_ext[31:0]};
    end
  end

  assign out_tdata = out_r;

  // Due time and goal, read by the scan pointer.
  eps_ram #(
    .WIDTH (CHKW),
    .DEPTH (MILESTONE_SLOTS)
  ) u_chk_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data ({goal_new, due_new}),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (chk_rdata)
  );

  // Creation time, read at the most recent slot.
  eps_ram #(
    .WIDTH (32),
    .DEPTH (MILESTONE_SLOTS)
  ) u_crt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (now_r),
    .rd_addr (last_r),
    .rd_data (crt_rdata)
  );

  `EPS_ASSERT_NXT(a_start_clears_ring, clk, rst_n, cmd_i.take && in_tuser == ACT_START,
    cnt_r == '0 && last_r == '0, "start did not clear the milestone ring")
  `EPS_ASSERT_IMP(a_stall_stops_motor, clk, rst_n, stall_r,
    ev_r && motion_r == MOT_STOPPED, "stall reported while the motor runs")
  `EPS_ASSERT_IMP(a_read_of_stored_slot, clk, rst_n, rd_vld_r,
    $past(ptr_r) < cnt_r, "scan read beyond the stored milestones")

endmodule

`default_nettype wire

// ===== src/encoder_position_stall_watch.sv =====
// Top level of the encoder position tracker with milestone stall watch.
//
// This block counts a motor's position from one encoder channel and stops the
// motor when it falls behind a schedule of milestones. Each input word carries
// an action in in_tuser (tick, start, stop) and produces exactly one result
// word with the position, the drive direction and stop flags. A start word
// clears the milestone ring and picks backward if its target lies below the
// position, forward otherwise; a stop word halts the motor and always reports
// stopped_event. On a tick while moving, a rising encoder level moves the
// position by one; then every stored milestone whose due time lies before
// now_us must have been reached, or the motor stops with stall_res set.
// Otherwise a new milestone is stored, at most one per interval, due one
// horizon later at the position plus or minus the configured event count.
// The first tick while moving after reset only records the encoder level.
// Items are taken one at a time: start, stop, unused actions and ticks while
// stopped go from accept straight to emit; a tick while moving is accepted,
// scans the stored milestones, passes an add step and is emitted, and the add
// step is skipped when the scan ends in a stall. The scan reads the milestone
// memory through its single read port, one slot per cycle. A finished result
// waits in the output register without holding up the next input word; only
// the load of the next result waits until the previous one has been taken.
// Configuration writes are accepted in every cycle and should be made only
// while the block is idle; indexes beyond the four registers are ignored.
// Milestone memory contents are undefined after reset and are only read once
// written after a start.
`default_nettype none

module encoder_position_stall_watch import eps_pkg::*; #(
  parameter int MILESTONE_SLOTS = 8,
  parameter int POSITION_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // target[31:0], encoder_level[32], now_us[64:33], zeros
  input  logic [1:0]  in_tuser,   // action[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // position[31:0], direction[33:32], stopped_event[34],
                                  // stall_res[35], zeros
);

  cmd_t cmd;
  sts_t sts;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  eps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eps_dp #(
    .MILESTONE_SLOTS (MILESTONE_SLOTS),
    .POSITION_BITS   (POSITION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the encoder position tracker with milestone stall watch.
module tb_top;
  import eps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The spare action code and two register indexes that decode to nothing.
  localparam logic [1:0] ACT_SPARE      = 2'd3;
  localparam logic [7:0] REG_UNUSED_LO  = 8'd4;
  localparam logic [7:0] REG_UNUSED_TOP = 8'hFF;

  localparam int SLOTS        = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 220;
  localparam int ERROR_PRINTS = 40;

  // One result word as the block reports it.
  typedef struct packed {
    logic [31:0] position;
    motion_t     direction;
    logic        stopped_event;
    logic        stall_res;
  } motor_report_t;

  // One input word, with an optional hand-written expectation.
  typedef struct packed {
    logic [1:0]    act;
    logic [31:0]   target;
    logic          lvl;
    logic [31:0]   now;
    logic          known;
    motor_report_t lit;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // target[31:0], encoder_level[32], now_us[64:33], zeros
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // position[31:0], direction[33:32], stopped_event[34],
                                // stall_res[35], zeros

  encoder_position_stall_watch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tracker: configuration, position, drive and milestone ring.
  logic [23:0] interval_cfg = RST_INTERVAL;
  logic [23:0] horizon_cfg  = RST_HORIZON;
  logic [15:0] fwd_need     = RST_REQ_FWD;
  logic [15:0] bwd_need     = RST_REQ_BWD;

  logic [31:0] pos_q = '0;
  motion_t     motion_q = MOT_STOPPED;
  logic        prev_lvl_q = 1'b0;
  logic        prev_lvl_ok = 1'b0;
  int          ms_count = 0;
  int          ms_last = 0;
  logic [31:0] ms_created [SLOTS];
  logic [31:0] ms_due [SLOTS];
  logic [31:0] ms_goal [SLOTS];

  motor_report_t expected_reports [$];
  plan_row_t     opening_plan [$];

  int errors = 0;
  int live_words = 0;
  int tick_words = 0, start_words = 0, stop_words = 0, spare_words = 0;
  int stalls_seen = 0, completions_seen = 0, results_seen = 0;
  int settings_used = 0;
  bit steady = 1'b0;

  task automatic note_mismatch(input string what);
    errors++;
    if (errors <= ERROR_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow tracker by one accepted word and return the report it yields.
  function automatic motor_report_t track_motor(input logic [1:0] act, input logic [31:0] target,
                                                input logic lvl, input logic [31:0] now);
    motor_report_t rep;
    logic          behind;
    int            slot;
    logic [31:0]   slot_open;
    rep.stopped_event = 1'b0;
    rep.stall_res = 1'b0;
    case (act)
      ACT_TICK: begin
        if (motion_q != MOT_STOPPED) begin
          // Only a rising level counts, and never on the first sample.
          if (prev_lvl_ok && !prev_lvl_q && lvl)
            pos_q = (motion_q == MOT_FWD) ? pos_q + 32'd1 : pos_q - 32'd1;
          prev_lvl_q = lvl;
          prev_lvl_ok = 1'b1;
          behind = 1'b0;
          for (int i = 0; i < ms_count; i++) begin
            if (ms_due[i] < now) begin
              if (motion_q == MOT_FWD && $signed(pos_q) < $signed(ms_goal[i])) behind = 1'b1;
              if (motion_q == MOT_BWD && $signed(ms_goal[i]) < $signed(pos_q)) behind = 1'b1;
            end
          end
          if (behind) begin
            motion_q = MOT_STOPPED;
            rep.stopped_event = 1'b1;
            rep.stall_res = 1'b1;
          end else begin
            slot = 0;
            slot_open = '0;
            if (ms_count > 0) begin
              slot_open = ms_created[ms_last] + {8'd0, interval_cfg};
              slot = (ms_last + 1) % SLOTS;
            end
            if (ms_count == 0 || now >= slot_open) begin
              ms_created[slot] = now;
              ms_due[slot] = now + {8'd0, horizon_cfg};
              ms_goal[slot] = (motion_q == MOT_FWD) ? pos_q + {16'd0, fwd_need}
                                                    : pos_q - {16'd0, bwd_need};
              if (ms_count < SLOTS) ms_count++;
              ms_last = slot;
            end
          end
        end
      end
      ACT_START: begin
        ms_count = 0;
        ms_last = 0;
        motion_q = ($signed(target) < $signed(pos_q)) ? MOT_BWD : MOT_FWD;
      end
      ACT_STOP: begin
        motion_q = MOT_STOPPED;
        rep.stopped_event = 1'b1;
      end
      default: ;
    endcase
    rep.position = pos_q;
    rep.direction = motion_q;
    return rep;
  endfunction

  // Present one word, wait for it to be taken, and queue what it should produce.
  // Valid is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input plan_row_t row);
    int            gap;
    motor_report_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= row.act;
    in_tdata <= {7'd0, row.now, row.lvl, row.target};
    do @(posedge clk); while (!in_tready);
    live_words++;
    case (row.act)
      ACT_TICK:  tick_words++;
      ACT_START: start_words++;
      ACT_STOP:  stop_words++;
      default:   spare_words++;
    endcase
    pred = track_motor(row.act, row.target, row.lvl, row.now);
    if (pred.stall_res) stalls_seen++;
    else if (pred.stopped_event) completions_seen++;
    expected_reports.push_back(row.known ? row.lit : pred);
  endtask

  // Write one register; the caller lowers cfg_valid after the last write of a group.
  task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INTERVAL: interval_cfg = val;
      REG_HORIZON:  horizon_cfg = val;
      REG_REQ_FWD:  fwd_need = val[15:0];
      REG_REQ_BWD:  bwd_need = val[15:0];
      default: ;
    endcase
  endtask

  // Let every outstanding result drain so that the block is idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Apply one register setting per phase; the extremes come first.
  task automatic load_phase(input int p);
    logic [23:0] iv, hz;
    logic [15:0] fw, bw;
    case (p)
      0: begin iv = '0;          hz = '0;          fw = '0;       bw = '0;       end
      1: begin iv = 24'hFFFFFF;  hz = 24'hFFFFFF;  fw = 16'hFFFF; bw = 16'hFFFF; end
      2: begin iv = 24'd20;      hz = 24'd100;     fw = 16'd3;    bw = 16'd3;    end
      3: begin iv = 24'd5;       hz = 24'd60;      fw = 16'd2;    bw = 16'd4;    end
      4: begin iv = 24'd0;       hz = 24'd40;      fw = 16'd1;    bw = 16'd1;    end
      5: begin
        iv = 24'($urandom_range(0, 40));
        hz = 24'($urandom_range(10, 200));
        fw = 16'($urandom_range(0, 6));
        bw = 16'($urandom_range(0, 6));
      end
      6: begin
        iv = 24'($urandom);
        hz = 24'($urandom);
        fw = 16'($urandom);
        bw = 16'($urandom);
      end
      default: begin iv = 24'd10; hz = 24'd200; fw = 16'hFFFF; bw = 16'd1; end
    endcase
    // The event-count registers are 16 bits wide, so junk in the top byte must be dropped.
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_HORIZON, hz);
    write_reg(REG_REQ_FWD, {8'($urandom), fw});
    write_reg(REG_REQ_BWD, {8'($urandom), bw});
    write_reg((p % 2 == 0) ? REG_UNUSED_LO : REG_UNUSED_TOP, 24'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic add_row(input logic [1:0] act, input logic [31:0] target, input logic lvl,
                         input logic [31:0] now, input logic known, input logic [31:0] pos,
                         input motion_t dir, input logic stop, input logic stall);
    plan_row_t r;
    r.act = act;
    r.target = target;
    r.lvl = lvl;
    r.now = now;
    r.known = known;
    r.lit.position = pos;
    r.lit.direction = dir;
    r.lit.stopped_event = stop;
    r.lit.stall_res = stall;
    opening_plan.push_back(r);
  endtask

  // Random part of one phase: mostly start words followed by a run of ticks with a
  // moving clock and toggling encoder, mixed with stray words of any kind.
  task automatic run_phase();
    plan_row_t   r;
    logic [31:0] clock_us;
    logic        enc_level;
    int          run_len;
    int          target_end;
    clock_us = $urandom;
    enc_level = 1'b0;
    target_end = live_words + PHASE_WORDS;
    while (live_words < target_end) begin
      if ($urandom_range(0, 3) == 0) clock_us = $urandom;
      r = '0;
      if ($urandom_range(0, 9) == 0) begin
        r.act = 2'($urandom_range(0, 3));
        r.target = $urandom;
        r.lvl = 1'($urandom_range(0, 1));
        r.now = clock_us + $urandom_range(0, 50);
        send_word(r);
      end else begin
        r.act = ACT_START;
        r.lvl = 1'($urandom_range(0, 1));
        r.now = $urandom;
        case ($urandom_range(0, 7))
          0: r.target = 32'h7FFF_FFFF;
          1: r.target = 32'h8000_0000;
          2: r.target = pos_q;
          default: r.target = $urandom;
        endcase
        send_word(r);
        run_len = $urandom_range(3, 50);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 59) == 0) begin
            r.act = ACT_STOP;
          end else begin
            r.act = ACT_TICK;
            if ($urandom_range(0, 2) != 0) enc_level = ~enc_level;
          end
          if ($urandom_range(0, 49) == 0) clock_us = clock_us + $urandom_range(0, 32'h01FF_FFFF);
          else if ($urandom_range(0, 4) == 0) clock_us = clock_us + $urandom_range(0, 400);
          else clock_us = clock_us + $urandom_range(0, 12);
          r.target = $urandom;
          r.lvl = enc_level;
          r.now = clock_us;
          send_word(r);
          // After a stop there is little left to see in this run.
          if (r.act == ACT_STOP) break;
          if (motion_q == MOT_STOPPED && $urandom_range(0, 9) < 7) break;
        end
      end
    end
  endtask

  // Result side: pace the ready with random stalls and check each word taken.
  int rx_hold = 0;

  always @(posedge clk) begin : rx_pace
    int g;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (out_tready) begin
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        rx_hold <= g - 1;
      end
    end else begin
      out_tready <= 1'b1;
      rx_hold <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin : report_check
    motor_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("result word %h arrived with nothing expected", out_tdata));
      end else begin
        want = expected_reports.pop_front();
        results_seen++;
        if (out_tdata[31:0] !== want.position)
          note_mismatch($sformatf("position %h, expected %h", out_tdata[31:0], want.position));
        if (out_tdata[33:32] !== want.direction)
          note_mismatch($sformatf("direction %0d, expected %0d", out_tdata[33:32],
                                  want.direction));
        if (out_tdata[34] !== want.stopped_event)
          note_mismatch($sformatf("stopped_event %b, expected %b", out_tdata[34],
                                  want.stopped_event));
        if (out_tdata[35] !== want.stall_res)
          note_mismatch($sformatf("stall_res %b, expected %b", out_tdata[35], want.stall_res));
      end
    end
  end

  // Stimulus: reset, a directed opening under the reset settings, then random phases.
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      ms_created[i] = '0;
      ms_due[i] = '0;
      ms_goal[i] = '0;
    end

    // Opening table. Rows with known set carry an expectation that follows directly
    // from the reset settings; the rest rely on the shadow tracker.
    // A tick while stopped does nothing, and a stop while stopped still reports a stop.
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd0,          1, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_STOP,  32'd0,          1'b0, 32'd0,          1, 32'd0, MOT_STOPPED, 1, 0);
    add_row(ACT_SPARE, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  1, 32'd0, MOT_STOPPED, 0, 0);
    // Direction choice at equal, lowest and highest targets; restarts while moving.
    add_row(ACT_START, 32'd0,          1'b0, 32'd0,          1, 32'd0, MOT_FWD,     0, 0);
    add_row(ACT_START, 32'h8000_0000,  1'b0, 32'd0,          1, 32'd0, MOT_BWD,     0, 0);
    add_row(ACT_START, 32'h7FFF_FFFF,  1'b1, 32'd0,          1, 32'd0, MOT_FWD,     0, 0);
    // The first tick while moving after reset only records the level, even when it is high.
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd1000,       1, 32'd0, MOT_FWD,     0, 0);
    add_row(ACT_TICK,  32'd0,          1'b0, 32'd1010,       0, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd1020,       0, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_TICK,  32'd0,          1'b0, 32'd101000,     0, 32'd0, MOT_STOPPED, 0, 0);
    // The first milestone is now overdue with the position short of it.
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd501001,     1, 32'd2, MOT_STOPPED, 1, 1);
    add_row(ACT_TICK,  32'd0,          1'b0, 32'd501002,     1, 32'd2, MOT_STOPPED, 0, 0);
    add_row(ACT_START, 32'd2,          1'b0, 32'd0,          1, 32'd2, MOT_FWD,     0, 0);
    add_row(ACT_START, 32'd1,          1'b0, 32'd0,          1, 32'd2, MOT_BWD,     0, 0);
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd10,         0, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_TICK,  32'd0,          1'b0, 32'd20,         0, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd30,         0, 32'd0, MOT_STOPPED, 0, 0);
    // Backward stall: the goal lies below the position once the milestone is due.
    add_row(ACT_TICK,  32'd0,          1'b1, 32'd500011,     1, 32'd1, MOT_STOPPED, 1, 1);
    add_row(ACT_START, 32'd5,          1'b0, 32'd0,          0, 32'd0, MOT_STOPPED, 0, 0);
    add_row(ACT_STOP,  32'd0,          1'b0, 32'd0,          1, 32'd1, MOT_STOPPED, 1, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_plan[i]) send_word(opening_plan[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_phase(p);
      // Two phases run without any gaps on either side.
      steady = (p == 2 || p == 5);
      run_phase();
    end
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d words (%0d ticks, %0d starts, %0d stops, %0d spare) under %0d settings.",
             tick_words + start_words + stop_words + spare_words, tick_words, start_words,
             stop_words, spare_words, settings_used + 1);
    $display("Checked %0d results, covering %0d stalls and %0d commanded stops.",
             results_seen, stalls_seen, completions_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
